// ===== hdl/srfd_pkg.sv =====
// shared types, constants and functions of the serial rc frame decoder
// no dependencies; imported by every module of the block
`default_nettype none

package srfd_pkg;

  localparam int FRAME_BUFFER_BYTES_DEF = 32;
  localparam int JOB_QUEUE_DEPTH        = 2;

  localparam logic [7:0]  SYNC_FIRST  = 8'hA8;
  localparam logic [7:0]  SYNC_SECOND = 8'h01;
  localparam logic [15:0] CRC_POLY    = 16'h1021;

  // per-count crc presets, covering the three header bytes
  localparam logic [15:0] CRC_PRESET_6  = 16'h47CA;
  localparam logic [15:0] CRC_PRESET_8  = 16'hA604;
  localparam logic [15:0] CRC_PRESET_10 = 16'h8646;
  localparam logic [15:0] CRC_PRESET_12 = 16'hE680;
  localparam logic [15:0] CRC_PRESET_14 = 16'hC6C2;

  // divide by five: floor(n * 52429 / 2^18) is exact for n below 2^16
  localparam logic [15:0] DIV5_MUL   = 16'd52429;
  localparam int          DIV5_SHIFT = 18;

  localparam int IN_TDATA_W  = 8;
  localparam int OUT_TDATA_W = 24;

  // configuration register indexes
  localparam logic CFG_FIRST_OFFSET = 1'b0;
  localparam logic CFG_OTHER_OFFSET = 1'b1;

  localparam logic [15:0] FIRST_OFFSET_RESET = 16'd8800;
  localparam logic [15:0] OTHER_OFFSET_RESET = 16'd12000;

  typedef struct packed {
    logic       we;
    logic       index;
    logic [15:0] data;
  } cfg_wr_t;

  // one finished frame handed from the parser to the result engine
  typedef struct packed {
    logic       ok;
    logic [3:0] count;
    logic       bank;
  } job_t;

  // result engine is done with a buffer bank
  typedef struct packed {
    logic en;
    logic bank;
  } bank_rel_t;

  function automatic logic count_supported(input logic [7:0] c);
    logic r;
    case (c) inside
      8'd6, 8'd8, 8'd10, 8'd12, 8'd14: r = 1'b1;
      default:                         r = 1'b0;
    endcase
    return r;
  endfunction

  function automatic logic [15:0] crc_preset(input logic [7:0] c);
    logic [15:0] r;
    case (c)
      8'd6:    r = CRC_PRESET_6;
      8'd8:    r = CRC_PRESET_8;
      8'd10:   r = CRC_PRESET_10;
      8'd12:   r = CRC_PRESET_12;
      8'd14:   r = CRC_PRESET_14;
      default: r = '0;
    endcase
    return r;
  endfunction

  // crc-16/xmodem over one byte, msb first
  function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {b, 8'h00};
    for (int i = 0; i < 8; i++) begin
      if (c[15]) begin
        c = {c[14:0], 1'b0} ^ CRC_POLY;
      end else begin
        c = {c[14:0], 1'b0};
      end
    end
    return c;
  endfunction

endpackage

`default_nettype wire

// ===== hdl/srfd_job_queue.sv =====
// short fifo of finished-frame jobs between parser and result engine
// depends on srfd_pkg
`default_nettype none

module srfd_job_queue
  import srfd_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic push,
  input  wire job_t push_job,
  input  wire logic pop,
  output job_t      head,
  output logic      empty,
  output logic      full
);

  localparam int PW = (JOB_QUEUE_DEPTH > 1) ? $clog2(JOB_QUEUE_DEPTH) : 1;
  localparam int CW = $clog2(JOB_QUEUE_DEPTH + 1);

  job_t          slots [JOB_QUEUE_DEPTH];
  logic [PW-1:0] wr_ptr;
  logic [PW-1:0] rd_ptr;
  logic [CW-1:0] fill;

  logic do_push;
  logic do_pop;

  assign empty   = (fill == '0);
  assign full    = (fill == CW'(JOB_QUEUE_DEPTH));
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign head    = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PW'(JOB_QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PW'(JOB_QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        fill <= fill + 1'b1;
      end else if (do_pop && !do_push) begin
        fill <= fill - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= push_job;
    end
  end

endmodule

`default_nettype wire

// ===== hdl/srfd_front.sv =====
// frame parser: sync search, byte counting, running crc, buffer writes
// depends on srfd_pkg; feeds srfd_job_queue and the buffer in srfd_back
`default_nettype none

module srfd_front
  import srfd_pkg::*;
#(
  parameter int FRAME_BUFFER_BYTES = FRAME_BUFFER_BYTES_DEF,
  localparam int WORDS = FRAME_BUFFER_BYTES / 2,
  localparam int AW    = $clog2(2 * WORDS)
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          s_tvalid,
  output logic               s_tready,
  input  wire logic [7:0]    s_tdata,
  output logic               job_push,
  output job_t               job,
  input  wire logic          q_full,
  input  wire bank_rel_t     rel,
  output logic               buf_we,
  output logic [AW-1:0]      buf_addr,
  output logic [15:0]        buf_wdata
);

  localparam logic [1:0] PH_SYNC1 = 2'd0;
  localparam logic [1:0] PH_SYNC2 = 2'd1;
  localparam logic [1:0] PH_COUNT = 2'd2;
  localparam logic [1:0] PH_DATA  = 2'd3;

  logic [1:0]  phase;
  logic [9:0]  frame_length;
  logic [9:0]  byte_count;
  logic        wr_bank;
  logic [1:0]  bank_busy;
  logic [7:0]  chan_count;
  logic [15:0] crc;
  logic [7:0]  hi_byte;
  logic [7:0]  got_hi;

  logic        accept;
  logic        data_byte;
  logic        in_payload;
  logic        is_end;
  logic [8:0]  word_idx;
  logic [1:0]  set_mask;
  logic [1:0]  clr_mask;

  assign s_tready   = !((phase == PH_DATA) && (bank_busy[wr_bank] || q_full));
  assign accept     = s_tvalid && s_tready;
  assign data_byte  = accept && (phase == PH_DATA);
  assign in_payload = byte_count < {1'b0, chan_count, 1'b0};
  assign is_end     = (byte_count + 10'd1) == frame_length;
  assign word_idx   = byte_count[9:1];

  assign job_push  = data_byte && is_end;
  assign job.ok    = count_supported(chan_count)
                  && (frame_length <= 10'(FRAME_BUFFER_BYTES))
                  && (crc == {got_hi, s_tdata});
  assign job.count = chan_count[3:0];
  assign job.bank  = wr_bank;

  // low byte of each channel word completes the write
  assign buf_we    = data_byte && in_payload && byte_count[0] && (word_idx < 9'(WORDS));
  assign buf_addr  = wr_bank ? AW'(WORDS) + AW'(word_idx) : AW'(word_idx);
  assign buf_wdata = {hi_byte, s_tdata};

  assign set_mask = {job_push && wr_bank, job_push && !wr_bank};
  assign clr_mask = {rel.en && rel.bank, rel.en && !rel.bank};

  always_ff @(posedge clk) begin
    if (rst) begin
      phase        <= PH_SYNC1;
      frame_length <= '0;
      byte_count   <= '0;
      wr_bank      <= 1'b0;
      bank_busy    <= '0;
    end else begin
      bank_busy <= (bank_busy | set_mask) & ~clr_mask;
      if (accept) begin
        unique case (phase)
          PH_SYNC1: begin
            if (s_tdata == SYNC_FIRST) begin
              phase        <= PH_SYNC2;
              byte_count   <= '0;
              frame_length <= '0;
            end
          end
          PH_SYNC2: begin
            if (s_tdata == SYNC_SECOND) begin
              phase <= PH_COUNT;
            end
          end
          PH_COUNT: begin
            frame_length <= {1'b0, s_tdata, 1'b0} + 10'd2;
            byte_count   <= '0;
            phase        <= PH_DATA;
          end
          PH_DATA: begin
            byte_count <= byte_count + 10'd1;
            if (is_end) begin
              phase   <= PH_SYNC1;
              wr_bank <= !wr_bank;
            end
          end
          default: phase <= PH_SYNC1;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept && (phase == PH_COUNT)) begin
      chan_count <= s_tdata;
      crc        <= crc_preset(s_tdata);
    end
    if (data_byte) begin
      if (in_payload) begin
        crc <= crc_byte(crc, s_tdata);
        if (!byte_count[0]) begin
          hi_byte <= s_tdata;
        end
      end
      if (byte_count == {1'b0, chan_count, 1'b0}) begin
        got_hi <= s_tdata;
      end
    end
  end

endmodule

`default_nettype wire

// ===== hdl/srfd_back.sv =====
// result engine: two-bank channel buffer, offset, divide by five, output register
// depends on srfd_pkg; pops jobs from srfd_job_queue
`default_nettype none

module srfd_back
  import srfd_pkg::*;
#(
  parameter int FRAME_BUFFER_BYTES = FRAME_BUFFER_BYTES_DEF,
  localparam int WORDS = FRAME_BUFFER_BYTES / 2,
  localparam int AW    = $clog2(2 * WORDS)
) (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire cfg_wr_t                cfg,
  input  wire logic                   buf_we,
  input  wire logic [AW-1:0]          buf_addr,
  input  wire logic [15:0]            buf_wdata,
  input  wire job_t                   head,
  input  wire logic                   q_empty,
  output logic                        q_pop,
  output bank_rel_t                   rel,
  output logic                        m_tvalid,
  input  wire logic                   m_tready,
  output logic [OUT_TDATA_W-1:0]      m_tdata,
  output logic                        m_tuser,
  output logic                        m_tlast
);

  localparam logic [2:0] BS_IDLE = 3'd0;
  localparam logic [2:0] BS_READ = 3'd1;
  localparam logic [2:0] BS_SUB  = 3'd2;
  localparam logic [2:0] BS_MUL  = 3'd3;
  localparam logic [2:0] BS_FIN  = 3'd4;
  localparam logic [2:0] BS_OUT  = 3'd5;

  logic [15:0] mem [2 * WORDS];
  logic [15:0] rd_data;
  logic [AW-1:0] rd_addr;

  logic [2:0]  state;
  logic [15:0] first_offset;
  logic [15:0] other_offset;
  job_t        cur;
  logic [3:0]  ch;
  logic [15:0] mag;
  logic        neg;
  logic [31:0] prod;
  logic [13:0] quot;

  logic        out_status;
  logic [3:0]  out_index;
  logic [14:0] out_value;
  logic        out_last;

  logic [16:0] diff;
  logic        done_ch;

  assign rd_addr = cur.bank ? AW'(WORDS) + AW'(ch) : AW'(ch);
  assign diff    = {1'b0, rd_data} - {1'b0, (ch == 4'd0) ? first_offset : other_offset};
  assign quot    = prod[DIV5_SHIFT +: 14];
  assign done_ch = (state == BS_OUT) && m_tready;

  assign q_pop    = (state == BS_IDLE) && !q_empty;
  assign rel.en   = done_ch && out_last;
  assign rel.bank = cur.bank;

  assign m_tvalid = (state == BS_OUT);
  assign m_tuser  = out_status;
  assign m_tlast  = out_last;
  assign m_tdata  = {{(OUT_TDATA_W - 19){1'b0}}, out_value, out_index};

  always_ff @(posedge clk) begin
    if (buf_we) begin
      mem[buf_addr] <= buf_wdata;
    end
    rd_data <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      first_offset <= FIRST_OFFSET_RESET;
      other_offset <= OTHER_OFFSET_RESET;
    end else if (cfg.we) begin
      unique case (cfg.index)
        CFG_FIRST_OFFSET: first_offset <= cfg.data;
        CFG_OTHER_OFFSET: other_offset <= cfg.data;
        default:          ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= BS_IDLE;
    end else begin
      unique case (state)
        BS_IDLE: if (!q_empty) state <= head.ok ? BS_READ : BS_OUT;
        BS_READ: state <= BS_SUB;
        BS_SUB:  state <= BS_MUL;
        BS_MUL:  state <= BS_FIN;
        BS_FIN:  state <= BS_OUT;
        BS_OUT:  if (m_tready) state <= out_last ? BS_IDLE : BS_READ;
        default: state <= BS_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      cur        <= head;
      ch         <= '0;
      out_status <= !head.ok;
      out_index  <= '0;
      out_value  <= '0;
      out_last   <= 1'b1;
    end
    if (state == BS_SUB) begin
      neg <= diff[16];
      mag <= diff[16] ? 16'(-diff) : diff[15:0];
    end
    if (state == BS_MUL) begin
      prod <= mag * DIV5_MUL;
    end
    if (state == BS_FIN) begin
      out_status <= 1'b0;
      out_index  <= ch;
      out_value  <= neg ? 15'(-{1'b0, quot}) : {1'b0, quot};
      out_last   <= (ch + 4'd1) == cur.count;
    end
    if (done_ch && !out_last) begin
      ch <= ch + 4'd1;
    end
  end

endmodule

`default_nettype wire

// ===== hdl/serial_rc_frame_decoder_top.sv =====
// Serial radio-control frame decoder. Received bytes stream in on the s_ side, one per
// transaction; the block hunts for sync 0xA8 then 0x01, takes a channel-count byte, then
// count*2 data bytes and a big-endian crc-16/xmodem. A frame of 6, 8, 10, 12 or 14
// channels with a matching crc gives one result per channel, (raw - offset) / 5 rounded
// toward zero, channel 0 using the first offset and the rest the other offset; anything
// else gives one rejection (tuser high, index and value zero, tlast high). Throughput:
// the parser takes one byte per cycle when not stalled and computes the crc on the fly,
// so nothing is left to compute at a frame's end. Channel words go into one of two buffer
// banks; a finished frame is queued as a job and the result engine works through it
// channel by channel through buffer read, offset subtract, reciprocal multiply, sign
// fix-up and output register, where a result waits while m_tready is low. The
// parser only stalls (s_tready low) on a data byte while both banks still hold frames
// whose results have not all been taken. Offsets are to be written through the cfg port
// only while the block is idle, by the user; the block itself does not enforce this.
// depends on srfd_pkg, srfd_front, srfd_job_queue, srfd_back
`default_nettype none

module serial_rc_frame_decoder_top
  import srfd_pkg::*;
#(
  parameter int FRAME_BUFFER_BYTES = FRAME_BUFFER_BYTES_DEF
) (
  input  wire logic                   clk,
  input  wire logic                   rst,
  // byte stream in
  input  wire logic                   s_tvalid,
  output logic                        s_tready,
  input  wire logic [IN_TDATA_W-1:0]  s_tdata,   // [7:0] rx_byte
  // channel results out
  output logic                        m_tvalid,
  input  wire logic                   m_tready,
  output logic [OUT_TDATA_W-1:0]      m_tdata,   // [3:0] channel_index, [18:4] channel_value, rest zero
  output logic                        m_tuser,   // [0] frame_status
  output logic                        m_tlast,   // last_of_frame
  // configuration writes
  input  wire logic                   cfg_we,
  input  wire logic                   cfg_index,
  input  wire logic [15:0]            cfg_data
);

  localparam int WORDS = FRAME_BUFFER_BYTES / 2;
  localparam int AW    = $clog2(2 * WORDS);

  job_t          job;
  job_t          head;
  logic          job_push;
  logic          q_pop;
  logic          q_empty;
  logic          q_full;
  bank_rel_t     rel;
  cfg_wr_t       cfg;
  logic          buf_we;
  logic [AW-1:0] buf_addr;
  logic [15:0]   buf_wdata;

  assign cfg.we    = cfg_we;
  assign cfg.index = cfg_index;
  assign cfg.data  = cfg_data;

  // parser: sync, count, crc, channel words into the free bank
  srfd_front #(
    .FRAME_BUFFER_BYTES(FRAME_BUFFER_BYTES)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .job_push  (job_push),
    .job       (job),
    .q_full    (q_full),
    .rel       (rel),
    .buf_we    (buf_we),
    .buf_addr  (buf_addr),
    .buf_wdata (buf_wdata)
  );

  // finished frames waiting for the result engine
  srfd_job_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (job_push),
    .push_job (job),
    .pop      (q_pop),
    .head     (head),
    .empty    (q_empty),
    .full     (q_full)
  );

  // result engine and output register
  srfd_back #(
    .FRAME_BUFFER_BYTES(FRAME_BUFFER_BYTES)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .buf_we    (buf_we),
    .buf_addr  (buf_addr),
    .buf_wdata (buf_wdata),
    .head      (head),
    .q_empty   (q_empty),
    .q_pop     (q_pop),
    .rel       (rel),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser),
    .m_tlast   (m_tlast)
  );

endmodule

`default_nettype wire

// ===== hdl/srfd_checker.sv =====
// port-level checks on the decoder's result stream, bound to the top level
// depends on srfd_pkg and serial_rc_frame_decoder_top
`default_nettype none

module srfd_checker
  import srfd_pkg::*;
(
  input wire logic                   clk,
  input wire logic                   rst,
  input wire logic                   m_tvalid,
  input wire logic                   m_tready,
  input wire logic [OUT_TDATA_W-1:0] m_tdata,
  input wire logic                   m_tuser,
  input wire logic                   m_tlast
);

  // nothing comes out in the cycle after reset
  a_quiet_after_reset: assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("result valid right after reset");

  // a rejection is a lone result with index and value zero
  a_reject_shape: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tuser) |-> (m_tlast && (m_tdata == '0)))
    else $error("malformed rejection result");

  // channel results stay in range and padding stays clear
  a_value_range: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tuser) |-> ((m_tdata[3:0] <= 4'd13)
      && ($signed(m_tdata[18:4]) <= 15'sd13107)
      && ($signed(m_tdata[18:4]) >= -15'sd13107)
      && (m_tdata[OUT_TDATA_W-1:19] == '0)))
    else $error("channel result out of range");

  // a stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)
      && $stable(m_tuser) && $stable(m_tlast)))
    else $error("result changed while stalled");

endmodule

bind serial_rc_frame_decoder_top srfd_checker u_srfd_checker (
  .clk      (clk),
  .rst      (rst),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tuser  (m_tuser),
  .m_tlast  (m_tlast)
);

`default_nettype wire

// ===== tb/sv/serial_rc_frame_decoder_top_tb.sv =====
// self-checking testbench for serial_rc_frame_decoder_top: byte stream in, channel results out
// carries its own frame parser and crc-16/xmodem decoder to predict every result
// depends on srfd_pkg and serial_rc_frame_decoder_top
`default_nettype none

module serial_rc_frame_decoder_top_tb;
  import srfd_pkg::*;

  localparam int CYCLE_LIMIT    = 1000000;
  localparam int SETTLE_CYCLES  = 100;   // longer than a 14-channel drain
  localparam int HOLD_OFF_CYCLES = 600;
  localparam int MAX_REPORTS    = 10;
  localparam int BUF_AW         = $clog2(FRAME_BUFFER_BYTES_DEF);

  typedef enum logic [1:0] {HUNT_SYNC1, HUNT_SYNC2, TAKE_COUNT, TAKE_DATA} parse_phase_t;

  typedef struct packed {
    logic        status;
    logic [3:0]  index;
    logic [14:0] value;
    logic        last;
  } chan_result_t;

  // dut ports, all inputs known from time zero
  logic                   clk = 1'b0;
  logic                   rst = 1'b1;
  logic                   s_tvalid = 1'b0;
  logic                   s_tready;
  logic [IN_TDATA_W-1:0]  s_tdata = '0;   // [7:0] rx_byte
  logic                   m_tvalid;
  logic                   m_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] m_tdata;        // [3:0] channel_index, [18:4] channel_value
  logic                   m_tuser;        // [0] frame_status
  logic                   m_tlast;        // last_of_frame
  logic                   cfg_we = 1'b0;
  logic                   cfg_index = CFG_FIRST_OFFSET;
  logic [15:0]            cfg_data = '0;

  // frame parser mirror, touched only by the stimulus thread
  parse_phase_t rx_phase = HUNT_SYNC1;
  logic [9:0]   rx_frame_len = '0;
  logic [9:0]   rx_byte_cnt = '0;
  logic [7:0]   rx_buf [FRAME_BUFFER_BYTES_DEF];
  logic [15:0]  first_offset = FIRST_OFFSET_RESET;
  logic [15:0]  other_offset = OTHER_OFFSET_RESET;

  chan_result_t awaited_channels [$];
  logic [7:0]   tx_frame [$];

  int  fault_count = 0;
  int  cycle_count = 0;
  bit  src_jitter = 1'b1;
  bit  sink_jitter = 1'b1;
  logic sink_hold = 1'b0;

  serial_rc_frame_decoder_top uut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser),
    .m_tlast   (m_tlast),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #5 clk = ~clk;

  // ---------------------------------------------------------------------------
  // prediction
  // ---------------------------------------------------------------------------

  // crc-16/xmodem, one bit at a time, msb first
  function automatic logic [15:0] crc_xmodem_update(input logic [15:0] crc, input logic [7:0] d);
    logic fb;
    for (int k = 7; k >= 0; k--) begin
      fb  = crc[15] ^ d[k];
      crc = {crc[14:0], 1'b0};
      if (fb) begin
        crc = crc ^ CRC_POLY;
      end
    end
    return crc;
  endfunction

  // the preset folds in the three header bytes; only even counts 6..14 have one
  function automatic bit lookup_preset(input int count, output logic [15:0] seed);
    seed = '0;
    case (count)
      6:       seed = CRC_PRESET_6;
      8:       seed = CRC_PRESET_8;
      10:      seed = CRC_PRESET_10;
      12:      seed = CRC_PRESET_12;
      14:      seed = CRC_PRESET_14;
      default: return 1'b0;
    endcase
    return 1'b1;
  endfunction

  // a frame has ended by length: work out its channel results or one rejection
  function automatic void decode_frame();
    int           count;
    int           raw;
    int           off;
    int           v;
    logic [15:0]  crc;
    logic [15:0]  got;
    chan_result_t r;
    count = (int'(rx_frame_len) - 2) / 2;
    if (!lookup_preset(count, crc) || rx_frame_len > FRAME_BUFFER_BYTES_DEF) begin
      awaited_channels.push_back(chan_result_t'{1'b1, 4'd0, 15'd0, 1'b1});
      return;
    end
    for (int i = 0; i < 2 * count; i++) begin
      crc = crc_xmodem_update(crc, rx_buf[i]);
    end
    got = {rx_buf[2 * count], rx_buf[2 * count + 1]};
    if (crc != got) begin
      awaited_channels.push_back(chan_result_t'{1'b1, 4'd0, 15'd0, 1'b1});
      return;
    end
    for (int i = 0; i < count; i++) begin
      raw = int'({rx_buf[2 * i], rx_buf[2 * i + 1]});
      off = (i == 0) ? int'(first_offset) : int'(other_offset);
      v   = (raw - off) / 5;   // sv integer division truncates toward zero
      r.status = 1'b0;
      r.index  = i[3:0];
      r.value  = v[14:0];
      r.last   = (i == count - 1);
      awaited_channels.push_back(r);
    end
  endfunction

  // one accepted byte through the parser mirror
  function automatic void absorb_byte(input logic [7:0] b);
    case (rx_phase)
      HUNT_SYNC1: begin
        if (b == SYNC_FIRST) begin
          rx_phase     = HUNT_SYNC2;
          rx_byte_cnt  = '0;
          rx_frame_len = '0;
        end
      end
      HUNT_SYNC2: begin
        // anything but the second sync is skipped, the hunt goes on
        if (b == SYNC_SECOND) begin
          rx_phase = TAKE_COUNT;
        end
      end
      TAKE_COUNT: begin
        rx_frame_len = {1'b0, b, 1'b0} + 10'd2;
        rx_byte_cnt  = '0;
        rx_phase     = TAKE_DATA;
      end
      default: begin
        // bytes past the buffer are counted but dropped
        if (rx_byte_cnt < FRAME_BUFFER_BYTES_DEF) begin
          rx_buf[rx_byte_cnt[BUF_AW-1:0]] = b;
        end
        rx_byte_cnt = rx_byte_cnt + 10'd1;
        if (rx_byte_cnt == rx_frame_len) begin
          rx_phase = HUNT_SYNC1;
          decode_frame();
        end
      end
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // result side: random back-pressure and the checker
  // ---------------------------------------------------------------------------

  initial begin : result_sink
    int           stall_left;
    chan_result_t want;
    chan_result_t got;
    stall_left = 0;
    forever begin
      @(posedge clk);
      if (m_tvalid && m_tready) begin
        got.status = m_tuser;
        got.index  = m_tdata[3:0];
        got.value  = m_tdata[18:4];
        got.last   = m_tlast;
        if (awaited_channels.size() == 0) begin
          if (fault_count < MAX_REPORTS) begin
            $display("unexpected result: status %0b index %0d value %0d last %0b",
                     got.status, got.index, $signed(got.value), got.last);
          end
          fault_count++;
        end else begin
          want = awaited_channels.pop_front();
          if (got !== want) begin
            if (fault_count < MAX_REPORTS) begin
              $display("result differs: expected status %0b index %0d value %0d last %0b,",
                       want.status, want.index, $signed(want.value), want.last);
              $display("  got status %0b index %0d value %0d last %0b",
                       got.status, got.index, $signed(got.value), got.last);
            end
            fault_count++;
          end
        end
      end
      // long hold-off from the pressure test wins over the random stalls
      if (sink_hold) begin
        m_tready <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        m_tready <= 1'b0;
      end else if (sink_jitter && $urandom_range(0, 99) < 25) begin
        stall_left = ($urandom_range(0, 9) == 0) ? int'($urandom_range(20, 60))
                                                 : int'($urandom_range(0, 3));
        m_tready <= 1'b0;
      end else begin
        m_tready <= 1'b1;
      end
    end
  end

  // run-away guard
  initial begin : watchdog
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("serial_rc_frame_decoder_top: mismatch");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // stimulus helpers
  // ---------------------------------------------------------------------------

  // offer one byte, optionally after a gap, and wait for the transaction
  task automatic send_byte(input logic [7:0] b);
    int gap;
    int pick;
    gap = 0;
    if (src_jitter) begin
      pick = $urandom_range(0, 99);
      if (pick >= 90) begin
        gap = $urandom_range(8, 40);
      end else if (pick >= 55) begin
        gap = $urandom_range(1, 3);
      end
    end
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= b;
    do @(posedge clk); while (!s_tready);
    absorb_byte(b);
  endtask

  // sync pair, count, big-endian channel words and crc; unsupported counts get a random crc
  task automatic build_frame(input int count, input bit spoil_crc, input bit extreme_raw);
    logic [15:0] crc;
    logic [15:0] raw;
    bit          known;
    tx_frame.delete();
    tx_frame.push_back(SYNC_FIRST);
    tx_frame.push_back(SYNC_SECOND);
    tx_frame.push_back(8'(count));
    known = lookup_preset(count, crc);
    for (int i = 0; i < count; i++) begin
      if (extreme_raw) begin
        case (i % 4)
          0:       raw = 16'h0000;
          1:       raw = 16'hFFFF;
          2:       raw = 16'h8000;
          default: raw = 16'h7FFF;
        endcase
      end else begin
        case ($urandom_range(0, 3))
          0:       raw = $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
          1:       raw = 16'($urandom);
          default: raw = 16'($urandom_range(8000, 16000));   // typical stick travel
        endcase
      end
      tx_frame.push_back(raw[15:8]);
      tx_frame.push_back(raw[7:0]);
      crc = crc_xmodem_update(crc_xmodem_update(crc, raw[15:8]), raw[7:0]);
    end
    if (!known) begin
      crc = 16'($urandom);
    end
    if (spoil_crc) begin
      crc = crc ^ (16'd1 << $urandom_range(0, 15));
    end
    tx_frame.push_back(crc[15:8]);
    tx_frame.push_back(crc[7:0]);
  endtask

  task automatic send_frame(input int count, input bit spoil_crc, input bit extreme_raw);
    build_frame(count, spoil_crc, extreme_raw);
    foreach (tx_frame[k]) begin
      send_byte(tx_frame[k]);
    end
  endtask

  // bring the parser back to hunting for the first sync; a partial frame ends as a rejection
  task automatic flush_parser();
    while (rx_phase != HUNT_SYNC1) begin
      send_byte((rx_phase == HUNT_SYNC2) ? SYNC_SECOND : 8'h00);
    end
  endtask

  // sender idle until every predicted result has been taken, then let the engine settle
  task automatic wait_drained();
    s_tvalid <= 1'b0;
    while (awaited_channels.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // offsets only change with the parser hunting and no result outstanding
  task automatic set_offsets(input logic [15:0] first, input logic [15:0] other);
    flush_parser();
    wait_drained();
    cfg_we    <= 1'b1;
    cfg_index <= CFG_FIRST_OFFSET;
    cfg_data  <= first;
    @(posedge clk);
    cfg_index <= CFG_OTHER_OFFSET;
    cfg_data  <= other;
    @(posedge clk);
    cfg_we       <= 1'b0;
    first_offset = first;
    other_offset = other;
  endtask

  task automatic hold_off_sink(input int cycles);
    sink_hold <= 1'b1;
    repeat (cycles) @(posedge clk);
    sink_hold <= 1'b0;
  endtask

  // ---------------------------------------------------------------------------
  // tests
  // ---------------------------------------------------------------------------

  // a broken sync pair, then a 6-channel frame of extreme words at the reset offsets
  task automatic test_sync_and_extremes();
    send_byte(SYNC_FIRST);
    send_byte(8'h55);        // wrong second sync, skipped
    send_byte(8'hFF);
    send_frame(6, 1'b0, 1'b1);
    send_byte(8'h00);        // stray byte while hunting
  endtask

  // bad crc, then a count past the buffer
  task automatic test_rejections();
    send_frame(6, 1'b1, 1'b0);
    send_frame(16, 1'b0, 1'b0);   // the two crc bytes fall outside the buffer
  endtask

  // channel zero lands on the negative limit and channel one on the positive limit
  task automatic test_offset_extremes();
    set_offsets(16'hFFFF, 16'h0000);
    send_frame(8, 1'b0, 1'b1);
  endtask

  // receiver holds off while frames keep coming, so both banks fill and input stalls;
  // the zero-count frame at the end is the one that waits on its first data byte
  task automatic test_fill_and_stall();
    src_jitter = 1'b0;
    fork
      hold_off_sink(HOLD_OFF_CYCLES);
      begin
        send_frame(14, 1'b0, 1'b0);
        send_frame(12, 1'b0, 1'b0);
        send_frame(0, 1'b0, 1'b0);
      end
    join
    src_jitter = 1'b1;
  endtask

  // sender waits for every result, then one frame without any idling on either side
  task automatic test_pause_and_drain();
    wait_drained();
    src_jitter  = 1'b0;
    sink_jitter = 1'b0;
    send_frame(10, 1'b0, 1'b0);
    src_jitter  = 1'b1;
    sink_jitter = 1'b1;
    wait_drained();
  endtask

  // ---------------------------------------------------------------------------
  // sequence
  // ---------------------------------------------------------------------------

  initial begin : stimulus
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_sync_and_extremes();
    test_rejections();
    test_offset_extremes();
    set_offsets(16'($urandom), 16'($urandom));
    test_fill_and_stall();
    test_pause_and_drain();

    wait_drained();
    if (fault_count == 0) begin
      $display("serial_rc_frame_decoder_top: match");
    end else begin
      $display("serial_rc_frame_decoder_top: mismatch");
    end
    $finish;
  end

endmodule

`default_nettype wire
